// ===== design/rtf_tl_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes and byte classifiers shared by the RTF token lexer files.
// No dependencies.
package rtf_tl_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_mode;

    // Token kinds as seen on the result channel
    localparam t_kind K_OPEN   = 3'd0;
    localparam t_kind K_CLOSE  = 3'd1;
    localparam t_kind K_LETTER = 3'd2;
    localparam t_kind K_WEND   = 3'd3;
    localparam t_kind K_SYMBOL = 3'd4;
    localparam t_kind K_HEX    = 3'd5;
    localparam t_kind K_TEXT   = 3'd6;
    localparam t_kind K_BIN    = 3'd7;

    // Lexer state codes; anything else behaves as idle
    localparam t_mode MODE_IDLE = 3'd0;
    localparam t_mode MODE_ESC  = 3'd1;
    localparam t_mode MODE_WORD = 3'd2;
    localparam t_mode MODE_NUM  = 3'd3;
    localparam t_mode MODE_HEX1 = 3'd4;
    localparam t_mode MODE_HEX2 = 3'd5;
    localparam t_mode MODE_SKIP = 3'd6;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;

    localparam logic [30:0] PARAM_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        t_kind       token_kind;
        logic [7:0]  char_value;
        logic [31:0] param_value;
        logic        has_param;
        logic        param_overflow;
        logic        last;
    } t_token;

    typedef struct packed {
        logic   emit;
        logic   esc;
        t_token tok;
    } t_idle;

    function automatic logic is_letter(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A]}) || (b inside {[8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})      r = {1'b1, b[3:0]};
        else if (b inside {[8'h61:8'h66]}) r = {1'b1, b[3:0] + 4'd9};
        else if (b inside {[8'h41:8'h46]}) r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

    // Byte seen between tokens: brace, backslash, dropped line end or text
    function automatic t_idle idle_byte(input logic [7:0] b);
        t_idle r;
        r = '0;
        if (b == CH_CR || b == CH_LF) begin
            r.emit = 1'b0;
        end else if (b == CH_OPEN) begin
            r.emit = 1'b1;
            r.tok.token_kind = K_OPEN;
        end else if (b == CH_CLOSE) begin
            r.emit = 1'b1;
            r.tok.token_kind = K_CLOSE;
        end else if (b == CH_BSL) begin
            r.esc = 1'b1;
        end else begin
            r.emit = 1'b1;
            r.tok.token_kind = K_TEXT;
            r.tok.char_value = b;
        end
        return r;
    endfunction

endpackage

// ===== design/rtf_tl_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the RTF token lexer: raw byte in, token word out.
// Depends on rtf_tl_pkg.
interface rtf_tl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rtf_tl_tok_if;
    import rtf_tl_pkg::*;

    logic               valid;
    logic               ready;
    t_kind              token_kind;
    logic [7:0]         char_value;
    logic signed [31:0] param_value;
    logic               has_param;
    logic               param_overflow;
    logic               last;

    modport source (output valid, output token_kind, output char_value, output param_value,
                    output has_param, output param_overflow, output last, input ready);
    modport sink   (input valid, input token_kind, input char_value, input param_value,
                    input has_param, input param_overflow, input last, output ready);
endinterface

// ===== design/rtf_token_lexer.sv =====
`timescale 1ns / 1ps
// Top level of the byte-serial RTF token lexer.
// Depends on rtf_tl_pkg and the channel interfaces in rtf_tl_if.
//
// Usage:
//   i_byte carries one raw RTF byte per word; o_tok carries one token word
//   (kind, character, parameter, flags, last). A byte gives zero, one or two
//   tokens; last marks the final token a byte caused.
//   The lexer state and the tokens of a byte are worked out in the cycle the
//   byte is accepted; the tokens land in a four-entry output queue and show
//   on o_tok once the tokens queued ahead of them have been taken.
//   Throughput: one byte per cycle while the receiver keeps up. i_byte.ready
//   is high whenever the queue has room for two tokens, so one queued token
//   waiting for the receiver does not hold off input. A byte that gives two
//   tokens fills two queue entries; a steady run of those is paced by the
//   single output port of the queue, which holds off input while they drain.
//   When the receiver stalls, the queue fills and i_byte.ready drops once
//   fewer than two entries are free; queued words hold until taken.
//   Reset (synchronous, active low) empties the queue and returns the lexer
//   to idle between tokens with the parameter state cleared.
module rtf_token_lexer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rtf_tl_byte_if.sink  i_byte,
    rtf_tl_tok_if.source o_tok
);
    import rtf_tl_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Lexer state
    t_mode       r_mode,   n_mode;
    logic [1:0]  r_bin,    n_bin;
    logic [30:0] r_accum,  n_accum;
    logic        r_neg,    n_neg;
    logic        r_seen,   n_seen;
    logic        r_ovf,    n_ovf;
    logic [7:0]  r_hex1,   n_hex1;
    logic [30:0] r_skip,   n_skip;

    // Output queue
    t_token          r_q [QDEPTH];
    logic [QAW-1:0]  r_head, r_tail;
    logic [QAW:0]    r_count;

    logic       w_acc, w_pop;
    logic [7:0] w_b;
    t_idle      w_idle;
    t_token     w_tok0, w_tok1;
    logic [1:0] w_push;
    logic [35:0] w_wide;
    logic [31:0] w_val;
    logic [4:0]  w_hi, w_lo;

    assign w_b    = i_byte.data_byte;
    assign w_acc  = i_byte.valid && i_byte.ready;
    assign w_pop  = o_tok.valid && o_tok.ready;
    assign w_idle = idle_byte(w_b);
    assign w_hi   = hex_val(r_hex1);
    assign w_lo   = hex_val(w_b);

    // accum * 10 + digit; magnitude above the 31-bit maximum is an overflow
    assign w_wide = {2'b00, r_accum, 3'b000} + {4'b0000, r_accum, 1'b0}
                  + {28'd0, w_b - CH_ZERO};

    // Parameter as reported at word end
    assign w_val = r_ovf ? 32'd0 :
                   (r_neg ? (32'd0 - {1'b0, r_accum}) : {1'b0, r_accum});

    assign i_byte.ready = (r_count <= (QAW+1)'(QDEPTH - 2));

    always_comb begin
        n_mode  = r_mode;
        n_bin   = r_bin;
        n_accum = r_accum;
        n_neg   = r_neg;
        n_seen  = r_seen;
        n_ovf   = r_ovf;
        n_hex1  = r_hex1;
        n_skip  = r_skip;
        w_tok0  = '0;
        w_tok1  = '0;
        w_push  = 2'd0;

        case (r_mode)
            MODE_SKIP: begin
                // drop the byte silently
                n_skip = (r_skip != 31'd0) ? r_skip - 31'd1 : 31'd0;
                if (n_skip == 31'd0) n_mode = MODE_IDLE;
            end
            MODE_HEX1: begin
                n_hex1 = w_b;
                n_mode = MODE_HEX2;
            end
            MODE_HEX2: begin
                w_tok0.token_kind = K_HEX;
                w_tok0.char_value = (w_hi[4] && w_lo[4]) ? {w_hi[3:0], w_lo[3:0]} : 8'd0;
                w_push = 2'd1;
                n_mode = MODE_IDLE;
            end
            MODE_ESC: begin
                if (is_letter(w_b)) begin
                    n_bin   = (w_b == CH_B) ? 2'd1 : 2'd0;
                    n_accum = '0;
                    n_neg   = 1'b0;
                    n_seen  = 1'b0;
                    n_ovf   = 1'b0;
                    w_tok0.token_kind = K_LETTER;
                    w_tok0.char_value = w_b;
                    w_push = 2'd1;
                    n_mode = MODE_WORD;
                end else if (w_b == CH_QUOTE) begin
                    n_mode = MODE_HEX1;
                end else begin
                    w_tok0.token_kind = K_SYMBOL;
                    w_tok0.char_value = w_b;
                    w_push = 2'd1;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_WORD, MODE_NUM: begin
                if (r_mode == MODE_WORD && is_letter(w_b)) begin
                    if (r_bin == 2'd1 && w_b == CH_I)      n_bin = 2'd2;
                    else if (r_bin == 2'd2 && w_b == CH_N) n_bin = 2'd3;
                    else                                   n_bin = 2'd0;
                    w_tok0.token_kind = K_LETTER;
                    w_tok0.char_value = w_b;
                    w_push = 2'd1;
                end else if (r_mode == MODE_WORD && w_b == CH_MINUS) begin
                    n_neg  = 1'b1;
                    n_mode = MODE_NUM;
                end else if (is_digit(w_b)) begin
                    n_seen = 1'b1;
                    n_mode = MODE_NUM;
                    if (!r_ovf) begin
                        if (w_wide > {5'd0, PARAM_MAX}) begin
                            n_ovf   = 1'b1;
                            n_accum = '0;
                        end else begin
                            n_accum = w_wide[30:0];
                        end
                    end
                end else begin
                    // word end: report the parameter; outside a binary run a non-space terminator is reprocessed
                    n_mode = MODE_IDLE;
                    w_tok0.param_value    = w_val;
                    w_tok0.has_param      = r_seen;
                    w_tok0.param_overflow = r_ovf;
                    w_tok0.token_kind     = (r_bin == 2'd3) ? K_BIN : K_WEND;
                    w_push = 2'd1;
                    if (r_bin == 2'd3 && !r_ovf && !r_neg && r_accum != 31'd0) begin
                        // binary run: a non-space terminator is the first skipped byte
                        n_skip = (w_b == CH_SPACE) ? r_accum : r_accum - 31'd1;
                        if (n_skip != 31'd0) n_mode = MODE_SKIP;
                    end else if (w_b != CH_SPACE) begin
                        if (w_idle.esc) n_mode = MODE_ESC;
                        if (w_idle.emit) begin
                            w_tok1 = w_idle.tok;
                            w_push = 2'd2;
                        end
                    end
                end
            end
            default: begin
                n_mode = w_idle.esc ? MODE_ESC : MODE_IDLE;
                if (w_idle.emit) begin
                    w_tok0 = w_idle.tok;
                    w_push = 2'd1;
                end
            end
        endcase

        // flag the final token of this byte
        if (w_push == 2'd1) w_tok0.last = 1'b1;
        if (w_push == 2'd2) w_tok1.last = 1'b1;
    end

    // Lexer state: advance on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_bin   <= 2'd0;
            r_accum <= '0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_ovf   <= 1'b0;
            r_hex1  <= 8'd0;
            r_skip  <= '0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_bin   <= n_bin;
            r_accum <= n_accum;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_ovf   <= n_ovf;
            r_hex1  <= n_hex1;
            r_skip  <= n_skip;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + QAW'(w_pop);
            r_tail  <= r_tail + (w_acc ? QAW'(w_push) : QAW'(0));
            r_count <= r_count + (w_acc ? (QAW+1)'(w_push) : (QAW+1)'(0))
                     - (QAW+1)'(w_pop);
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (w_acc && w_push != 2'd0) r_q[r_tail] <= w_tok0;
        if (w_acc && w_push == 2'd2) r_q[r_tail + QAW'(1)] <= w_tok1;
    end

    assign o_tok.valid          = (r_count != '0);
    assign o_tok.token_kind     = r_q[r_head].token_kind;
    assign o_tok.char_value     = r_q[r_head].char_value;
    assign o_tok.param_value    = $signed(r_q[r_head].param_value);
    assign o_tok.has_param      = r_q[r_head].has_param;
    assign o_tok.param_overflow = r_q[r_head].param_overflow;
    assign o_tok.last           = r_q[r_head].last;

endmodule

// ===== design/rtf_tl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RTF token lexer, bound to the top level.
// Depends on rtf_tl_pkg and rtf_token_lexer.
module rtf_tl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input rtf_tl_pkg::t_kind  i_kind,
    input logic [7:0]         i_char,
    input logic [31:0]        i_param,
    input logic               i_has_param,
    input logic               i_ovf,
    input logic               i_last
);
    import rtf_tl_pkg::*;

    // a stalled token word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_char)
            && $stable(i_param) && $stable(i_has_param) && $stable(i_ovf) && $stable(i_last))
        else $error("token word changed while stalled");

    // only word end and binary start carry parameter fields
    a_param_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !(i_kind == K_WEND || i_kind == K_BIN)
            |-> i_param == 32'd0 && !i_has_param && !i_ovf)
        else $error("parameter fields on a token without parameter");

    // an overflowed parameter reads as zero
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ovf |-> i_param == 32'd0 && i_has_param)
        else $error("overflowed parameter not reported as zero");

    // kinds without a character carry zero
    a_char_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == K_OPEN || i_kind == K_CLOSE || i_kind == K_WEND
            || i_kind == K_BIN) |-> i_char == 8'd0)
        else $error("character on a token kind without one");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token word valid right after reset");

endmodule

bind rtf_token_lexer rtf_tl_checker u_rtf_tl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_kind      (o_tok.token_kind),
    .i_char      (o_tok.char_value),
    .i_param     (o_tok.param_value),
    .i_has_param (o_tok.has_param),
    .i_ovf       (o_tok.param_overflow),
    .i_last      (o_tok.last)
);
